@@ src/fers_pkg.sv @@
// Shared types, codes and constants for the flash erase range sequencer.
`timescale 1ns / 1ps

package fers_pkg;

	localparam int unsigned DEFAULT_ADDR_BITS = 32;
	localparam int unsigned SIZE_W            = 26;
	localparam int unsigned WORD_W            = 32;

	localparam int unsigned SECTOR_BYTES = 4096;
	localparam int unsigned BLOCK_BYTES  = 65536;

	// Command codes of an input beat.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DONE  = 1'b1;

	// Erase kinds.
	localparam logic KIND_SECTOR = 1'b0;
	localparam logic KIND_BLOCK  = 1'b1;

	// Status codes of a result beat.
	localparam logic [2:0] ST_ERASING    = 3'd0;
	localparam logic [2:0] ST_DONE       = 3'd1;
	localparam logic [2:0] ST_RANGE      = 3'd2;
	localparam logic [2:0] ST_ALIGN      = 3'd3;
	localparam logic [2:0] ST_FAILED     = 3'd4;
	localparam logic [2:0] ST_UNEXPECTED = 3'd5;

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] start_address;
		logic [WORD_W-1:0] byte_count;
		logic              erase_failed;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              issue_erase;
		logic              erase_kind;
		logic [WORD_W-1:0] erase_address;
	} result_t;

endpackage

@@ src/fers_in_stage.sv @@
// Input register stage: captures one request beat and holds it for the planner.
`timescale 1ns / 1ps

module fers_in_stage
	import fers_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t req_in,
	input  logic advance,
	output logic valid_s1,
	output req_t req_s1
);

	// The held beat moves on when the planner hands it to the result register.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= req_in;
		end
	end

endmodule

@@ src/fers_plan.sv @@
// Erase planner: checks requests, picks sector or block erases and keeps the job state.
`timescale 1ns / 1ps

module fers_plan
	import fers_pkg::*;
#(
	parameter int unsigned ADDR_BITS = DEFAULT_ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  req_t              req,
	input  logic [SIZE_W-1:0] dev_size,
	output result_t           result
);

	localparam logic [WORD_W:0]    SPACE    = (WORD_W+1)'(64'd1 << ADDR_BITS);
	localparam logic [ADDR_BITS:0] BLK_STEP = (ADDR_BITS+1)'(BLOCK_BYTES);
	localparam logic [ADDR_BITS:0] SEC_STEP = (ADDR_BITS+1)'(SECTOR_BYTES);

	logic                 active_q;
	logic [ADDR_BITS-1:0] cur_addr_q;
	logic [ADDR_BITS:0]   end_addr_q;
	logic                 blk_q;

	logic [WORD_W:0]      req_end;
	logic                 range_bad;
	logic                 align_bad;
	logic [ADDR_BITS:0]   next_addr;
	logic [ADDR_BITS-1:0] sel_cur;
	logic [ADDR_BITS:0]   sel_end;
	logic [ADDR_BITS:0]   remain;
	logic                 pick_blk;

	logic                 issue;
	logic [2:0]           st;
	logic                 active_d;

	// End of the requested range, formed one bit wider so it cannot wrap.
	assign req_end   = {1'b0, req.start_address} + {1'b0, req.byte_count};
	assign range_bad = (req_end > (WORD_W+1)'(dev_size)) || (req_end > SPACE);
	assign align_bad = (|req.start_address[11:0]) || (|req.byte_count[11:0]);

	// Address right after the erase that just finished.
	assign next_addr = {1'b0, cur_addr_q} + (blk_q ? BLK_STEP : SEC_STEP);

	// Candidate erase: a fresh request or the continuation of the running job.
	assign sel_cur  = (req.command == CMD_START) ? req.start_address[ADDR_BITS-1:0]
	                                             : next_addr[ADDR_BITS-1:0];
	assign sel_end  = (req.command == CMD_START) ? req_end[ADDR_BITS:0] : end_addr_q;
	assign remain   = sel_end - {1'b0, sel_cur};
	assign pick_blk = (sel_cur[15:0] == 16'd0) && (remain >= BLK_STEP);

	always_comb begin
		issue    = 1'b0;
		st       = ST_DONE;
		active_d = 1'b0;
		unique case (req.command)
			CMD_START: begin
				priority if (req.byte_count == '0) begin
					st = ST_DONE;
				end else if (range_bad) begin
					st = ST_RANGE;
				end else if (align_bad) begin
					st = ST_ALIGN;
				end else begin
					st       = ST_ERASING;
					issue    = 1'b1;
					active_d = 1'b1;
				end
			end
			CMD_DONE: begin
				priority if (!active_q) begin
					st = ST_UNEXPECTED;
				end else if (req.erase_failed) begin
					st = ST_FAILED;
				end else if (next_addr < end_addr_q) begin
					st       = ST_ERASING;
					issue    = 1'b1;
					active_d = 1'b1;
				end else begin
					st = ST_DONE;
				end
			end
			default: begin
				st = ST_DONE;
			end
		endcase
	end

	assign result.status        = st;
	assign result.issue_erase   = issue;
	assign result.erase_kind    = issue ? pick_blk : KIND_SECTOR;
	assign result.erase_address = issue ? WORD_W'(sel_cur) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			cur_addr_q <= '0;
			end_addr_q <= '0;
			blk_q      <= 1'b0;
		end else if (fire) begin
			// An unexpected completion leaves the idle state untouched.
			if (!(req.command == CMD_DONE && !active_q)) begin
				active_q <= active_d;
			end
			if (issue) begin
				cur_addr_q <= sel_cur;
				end_addr_q <= sel_end;
				blk_q      <= pick_blk;
			end
		end
	end

endmodule

@@ src/fers_out_stage.sv @@
// Result register: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps

module fers_out_stage
	import fers_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_valid,
	input  result_t load_res,
	output logic    ready,
	output logic    valid_s2,
	input  logic    out_stall,
	output result_t res_s2
);

	assign ready = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load_valid) begin
			res_s2 <= load_res;
		end
	end

endmodule

@@ src/flash_erase_range_sequencer_top.sv @@
// Top level of the flash erase range sequencer: ports, size register and stage wiring.
`timescale 1ns / 1ps

// Plans the erase of a byte range on a NOR flash as a series of 4 KiB sector
// and 64 KiB block erases. A start beat (command 0) carries an address and a
// length; it is checked in order for an empty length (done at once), a range
// end past the configured flash size or the address space (out of range), and
// 4 KiB misalignment. A good request immediately issues its first erase, a
// block erase when the address is 64 KiB aligned and at least 64 KiB remain,
// a sector erase otherwise. Each completion beat (command 1) then issues the
// next erase, reports done, or reports a failure; a completion while no job is
// running reports an unexpected completion. A start beat always abandons any
// running job. Every input beat yields exactly one result beat. The block
// takes one beat per cycle while out_stall is low: a beat is held in the
// input register, where the planner evaluates it against the job state, and
// its result is presented from the result register. in_stall rises only
// when the result register is full and stalled while the input register
// also holds a beat. The device size register resets to zero and is written
// through cfg_write_en and cfg_write_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.

module flash_erase_range_sequencer_top
	import fers_pkg::*;
#(
	parameter int unsigned ADDR_BITS = DEFAULT_ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_write_en,
	input  logic [SIZE_W-1:0] cfg_write_data,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [WORD_W-1:0] start_address,
	input  logic [WORD_W-1:0] byte_count,
	input  logic              erase_failed,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic              issue_erase,
	output logic              erase_kind,
	output logic [WORD_W-1:0] erase_address
);

	logic [SIZE_W-1:0] dev_size_q;

	req_t    req_in;
	req_t    req_s1;
	logic    valid_s1;
	logic    out_ready;
	logic    advance;
	result_t plan_res;
	result_t res_s2;

	// Device size used by the range check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_size_q <= '0;
		end else if (cfg_write_en) begin
			dev_size_q <= cfg_write_data;
		end
	end

	assign req_in.command       = command;
	assign req_in.start_address = start_address;
	assign req_in.byte_count    = byte_count;
	assign req_in.erase_failed  = erase_failed;

	// A held beat is planned and committed in the cycle the result register can take it.
	assign advance = valid_s1 && out_ready;

	fers_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_in   (req_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	fers_plan #(
		.ADDR_BITS (ADDR_BITS)
	) u_plan (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.req      (req_s1),
		.dev_size (dev_size_q),
		.result   (plan_res)
	);

	fers_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_res   (plan_res),
		.ready      (out_ready),
		.valid_s2   (out_valid),
		.out_stall  (out_stall),
		.res_s2     (res_s2)
	);

	assign status        = res_s2.status;
	assign issue_erase   = res_s2.issue_erase;
	assign erase_kind    = res_s2.erase_kind;
	assign erase_address = res_s2.erase_address;

endmodule
